// File: hdl/sem_pkg.sv
// sem_pkg: shared constants, types and register codes for the exchange
// stencil matrix entry generator
// no dependencies
package sem_pkg;

   localparam int DEF_MAX_NX = 64;
   localparam int DEF_MAX_NY = 64;
   localparam int DEF_MAX_NZ = 64;
   localparam int COMPONENTS = 3;
   localparam int CMP_W      = 2;

   localparam int GRID_W     = 7;
   localparam int STIFF_W    = 32;
   localparam int COEF_W     = 32;
   localparam int PROD_W     = COEF_W + STIFF_W;
   localparam int IDX_W      = 20;
   localparam int VAL_W      = 48;

   localparam int NBR        = 6;
   localparam int KIDX_W     = 3;

   localparam int WEIGHT_W   = 18;
   localparam int W_ONE      = 65536;
   localparam int W_SHIFT    = 14;
   localparam int MUL_STEPS  = 32;
   localparam int CNT_W      = 5;

   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic [CSR_IDX_W-1:0] CSR_GRID_X     = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_GRID_Y     = CSR_IDX_W'(1);
   localparam logic [CSR_IDX_W-1:0] CSR_GRID_Z     = CSR_IDX_W'(2);
   localparam logic [CSR_IDX_W-1:0] CSR_COEF_X     = CSR_IDX_W'(3);
   localparam logic [CSR_IDX_W-1:0] CSR_COEF_Y     = CSR_IDX_W'(4);
   localparam logic [CSR_IDX_W-1:0] CSR_COEF_Z     = CSR_IDX_W'(5);
   localparam logic [CSR_IDX_W-1:0] CSR_UNIFORM    = CSR_IDX_W'(6);
   localparam logic [CSR_IDX_W-1:0] CSR_UNIF_STIFF = CSR_IDX_W'(7);

   localparam logic [KIDX_W-1:0] NBR_XP = KIDX_W'(0);
   localparam logic [KIDX_W-1:0] NBR_XM = KIDX_W'(1);
   localparam logic [KIDX_W-1:0] NBR_YP = KIDX_W'(2);
   localparam logic [KIDX_W-1:0] NBR_YM = KIDX_W'(3);
   localparam logic [KIDX_W-1:0] NBR_ZP = KIDX_W'(4);
   localparam logic [KIDX_W-1:0] NBR_ZM = KIDX_W'(5);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ROW_Z,
      ST_ROW_Y,
      ST_ROW_X,
      ST_SCAN,
      ST_CALC,
      ST_EMIT
   } sem_state_type;

   typedef enum logic [1:0] {
      PH_IDLE,
      PH_MULDIV,
      PH_WEIGHT
   } sem_phase_type;

   typedef struct packed {
      logic [COEF_W-1:0]  coef;
      logic [STIFF_W-1:0] ai;
      logic [STIFF_W-1:0] an;
      logic               uniform;
   } sem_arith_req_type;

endpackage

// File: hdl/sem_arith.sv
// sem_arith: bit-serial entry value unit, coef*ai multiply overlapped with the
// harmonic weight division, then the weighting multiply and 48-bit saturation
// depends on sem_pkg
module sem_arith (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  sem_pkg::sem_arith_req_type    req,
   output logic                          done,
   output logic [sem_pkg::VAL_W-1:0]     value
);

   localparam int CW  = sem_pkg::COEF_W;
   localparam int SW  = sem_pkg::STIFF_W;
   localparam int PW  = sem_pkg::PROD_W;
   localparam int WW  = sem_pkg::WEIGHT_W;
   localparam int NW  = sem_pkg::CNT_W;
   localparam int VW  = sem_pkg::VAL_W;
   localparam int WS  = sem_pkg::W_SHIFT;

   sem_pkg::sem_phase_type phase_ff, phase_in;
   logic [NW-1:0]   cnt_ff, cnt_in;
   logic [CW-1:0]   coef_ff, coef_in;
   logic [CW-1:0]   mhi_ff, mhi_in;
   logic [SW-1:0]   mlo_ff, mlo_in;
   logic [SW:0]     den_ff, den_in;
   logic [SW+1:0]   rem_ff, rem_in;
   logic [WW-1:0]   q_ff, q_in;
   logic            uni_ff, uni_in;
   logic [PW-1:0]   whi_ff, whi_in;
   logic [WW-1:0]   wr_ff, wr_in;
   logic [VW-1:0]   value_ff, value_in;

   logic [CW:0]     msum;
   logic [SW+1:0]   rem_sh;
   logic            div_ge;
   logic [WW-1:0]   weight;
   logic [PW-1:0]   prod;
   logic [PW:0]     wsum;
   logic [PW-1:0]   wnew;
   logic            sat;
   logic            mul_last;
   logic            w_last;

   assign mul_last = (cnt_ff == NW'(sem_pkg::MUL_STEPS - 1));
   assign w_last   = (cnt_ff == NW'(WW - 1));

   // next phase
   always_comb begin
      phase_in = phase_ff;
      case (phase_ff)
         sem_pkg::PH_IDLE: begin
            if (start) phase_in = sem_pkg::PH_MULDIV;
         end
         sem_pkg::PH_MULDIV: begin
            if (mul_last) phase_in = sem_pkg::PH_WEIGHT;
         end
         sem_pkg::PH_WEIGHT: begin
            if (w_last) phase_in = sem_pkg::PH_IDLE;
         end
         default: phase_in = sem_pkg::PH_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      done  = (phase_ff == sem_pkg::PH_WEIGHT) && w_last;
      value = value_ff;
   end

   // serial steps
   always_comb begin
      msum   = {1'b0, mhi_ff} + (mlo_ff[0] ? {1'b0, coef_ff} : '0);
      rem_sh = (cnt_ff == '0) ? rem_ff : {rem_ff[SW:0], 1'b0};
      div_ge = (rem_sh >= (SW+2)'(den_ff));
      weight = uni_ff ? WW'(sem_pkg::W_ONE) : ((den_ff == '0) ? '0 : q_ff);
      prod   = {mhi_ff, mlo_ff};
      wsum   = {1'b0, whi_ff} + (wr_ff[0] ? {1'b0, prod} : '0);
      wnew   = wsum[PW:1];
      sat    = |wnew[PW-1:WS+VW];
   end

   always_comb begin
      cnt_in   = cnt_ff;
      coef_in  = coef_ff;
      mhi_in   = mhi_ff;
      mlo_in   = mlo_ff;
      den_in   = den_ff;
      rem_in   = rem_ff;
      q_in     = q_ff;
      uni_in   = uni_ff;
      whi_in   = whi_ff;
      wr_in    = wr_ff;
      value_in = value_ff;
      case (phase_ff)
         sem_pkg::PH_IDLE: begin
            if (start) begin
               cnt_in  = '0;
               coef_in = req.coef;
               mhi_in  = '0;
               mlo_in  = req.ai;
               den_in  = (SW+1)'(req.an) + (SW+1)'(req.ai);
               rem_in  = (SW+2)'(req.an);
               q_in    = '0;
               uni_in  = req.uniform;
            end
         end
         sem_pkg::PH_MULDIV: begin
            mhi_in = msum[CW:1];
            mlo_in = {msum[0], mlo_ff[SW-1:1]};
            if (cnt_ff < NW'(WW)) begin
               rem_in = div_ge ? (rem_sh - (SW+2)'(den_ff)) : rem_sh;
               q_in   = {q_ff[WW-2:0], div_ge};
            end
            if (mul_last) begin
               cnt_in = '0;
               whi_in = '0;
               wr_in  = weight;
            end else begin
               cnt_in = cnt_ff + NW'(1);
            end
         end
         sem_pkg::PH_WEIGHT: begin
            whi_in = wnew;
            wr_in  = {wsum[0], wr_ff[WW-1:1]};
            cnt_in = cnt_ff + NW'(1);
            if (w_last) begin
               value_in = sat ? '1 : wnew[WS+VW-1:WS];
            end
         end
         default: begin
            cnt_in = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= sem_pkg::PH_IDLE;
         cnt_ff   <= '0;
      end else begin
         phase_ff <= phase_in;
         cnt_ff   <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      coef_ff  <= coef_in;
      mhi_ff   <= mhi_in;
      mlo_ff   <= mlo_in;
      den_ff   <= den_in;
      rem_ff   <= rem_in;
      q_ff     <= q_in;
      uni_ff   <= uni_in;
      whi_ff   <= whi_in;
      wr_ff    <= wr_in;
      value_ff <= value_in;
   end

endmodule

// File: hdl/stencil_exchange_matrix_entries_top.sv
// stencil_exchange_matrix_entries_top: row sequencer, cell counters and
// output register of the exchange stencil off-diagonal entry generator
// depends on sem_pkg and sem_arith
//
// usage
//   req_ beat: stiffness of the current cell and its six neighbours for the
//   next matrix row; rows follow x fastest, then y, z and field component.
//   rsp_ beat: one off-diagonal entry (row, column, value, last-of-row), in
//   neighbour order +x, -x, +y, -y, +z, -z; out-of-grid neighbours are
//   skipped, and in per-cell mode a row whose own stiffness is zero has none.
//   csr_ port: plain register writes, only while the block is idle.
// sequence
//   one row at a time: index setup in ROW_Z, ROW_Y and ROW_X after the req_
//   beat, then a scan over the neighbour slots in order, back to idle once
//   all six are scanned; each emitted entry runs the bit-serial unit (a
//   32-step multiply with the weight division beside it, then an 18-step
//   weighting multiply) and then gives one rsp_ beat.
// reset
//   counters go to cell 0 of component 0, grids to 1, coefficients and
//   uniform stiffness to 0, uniform mode on.
// stall
//   an entry holds on the rsp_ port until rsp_ready; nothing is dropped and
//   req_ready stays low until the row is complete.
module stencil_exchange_matrix_entries_top #(
   parameter int MAX_NX = sem_pkg::DEF_MAX_NX,
   parameter int MAX_NY = sem_pkg::DEF_MAX_NY,
   parameter int MAX_NZ = sem_pkg::DEF_MAX_NZ
) (
   input  logic                              clock,
   input  logic                              reset,

   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [sem_pkg::STIFF_W-1:0]       req_a_self,
   input  logic [sem_pkg::STIFF_W-1:0]       req_a_xp,
   input  logic [sem_pkg::STIFF_W-1:0]       req_a_xm,
   input  logic [sem_pkg::STIFF_W-1:0]       req_a_yp,
   input  logic [sem_pkg::STIFF_W-1:0]       req_a_ym,
   input  logic [sem_pkg::STIFF_W-1:0]       req_a_zp,
   input  logic [sem_pkg::STIFF_W-1:0]       req_a_zm,

   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [sem_pkg::IDX_W-1:0]         rsp_row_index,
   output logic [sem_pkg::IDX_W-1:0]         rsp_col_index,
   output logic [sem_pkg::VAL_W-1:0]         rsp_entry_value,
   output logic                              rsp_row_last,

   input  logic                              csr_write_en,
   input  logic [sem_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [sem_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   localparam int XW = $clog2(MAX_NX + 1);
   localparam int YW = $clog2(MAX_NY + 1);
   localparam int ZW = $clog2(MAX_NZ + 1);
   localparam int GW = sem_pkg::GRID_W;
   localparam int SW = sem_pkg::STIFF_W;
   localparam int CW = sem_pkg::COEF_W;
   localparam int IW = sem_pkg::IDX_W;
   localparam int KW = sem_pkg::KIDX_W;
   localparam int MW = sem_pkg::CMP_W;
   localparam int NB = sem_pkg::NBR;

   // configuration registers
   logic [GW-1:0] grid_x_ff, grid_y_ff, grid_z_ff;
   logic [CW-1:0] coef_x_ff, coef_y_ff, coef_z_ff;
   logic          uniform_ff;
   logic [SW-1:0] ustiff_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         grid_x_ff  <= GW'(1);
         grid_y_ff  <= GW'(1);
         grid_z_ff  <= GW'(1);
         coef_x_ff  <= '0;
         coef_y_ff  <= '0;
         coef_z_ff  <= '0;
         uniform_ff <= 1'b1;
         ustiff_ff  <= '0;
      end else if (csr_write_en) begin
         case (csr_index)
            sem_pkg::CSR_GRID_X:     grid_x_ff  <= csr_wdata[GW-1:0];
            sem_pkg::CSR_GRID_Y:     grid_y_ff  <= csr_wdata[GW-1:0];
            sem_pkg::CSR_GRID_Z:     grid_z_ff  <= csr_wdata[GW-1:0];
            sem_pkg::CSR_COEF_X:     coef_x_ff  <= csr_wdata[CW-1:0];
            sem_pkg::CSR_COEF_Y:     coef_y_ff  <= csr_wdata[CW-1:0];
            sem_pkg::CSR_COEF_Z:     coef_z_ff  <= csr_wdata[CW-1:0];
            sem_pkg::CSR_UNIFORM:    uniform_ff <= csr_wdata[0];
            sem_pkg::CSR_UNIF_STIFF: ustiff_ff  <= csr_wdata[SW-1:0];
            default: ;
         endcase
      end
   end

   // clamped grid sizes
   logic [XW-1:0] nx;
   logic [YW-1:0] ny;
   logic [ZW-1:0] nz;

   always_comb begin
      nx = (grid_x_ff == '0) ? XW'(1) :
           ((32'(grid_x_ff) > 32'(MAX_NX)) ? XW'(MAX_NX) : XW'(grid_x_ff));
      ny = (grid_y_ff == '0) ? YW'(1) :
           ((32'(grid_y_ff) > 32'(MAX_NY)) ? YW'(MAX_NY) : YW'(grid_y_ff));
      nz = (grid_z_ff == '0) ? ZW'(1) :
           ((32'(grid_z_ff) > 32'(MAX_NZ)) ? ZW'(MAX_NZ) : ZW'(grid_z_ff));
   end

   // state and working registers
   sem_pkg::sem_state_type state_ff, state_in;
   logic [XW-1:0] cell_x_ff, cell_x_in;
   logic [YW-1:0] cell_y_ff, cell_y_in;
   logic [ZW-1:0] cell_z_ff, cell_z_in;
   logic [MW-1:0] comp_ff, comp_in;
   logic [XW-1:0] cur_x_ff, cur_x_in;
   logic [YW-1:0] cur_y_ff, cur_y_in;
   logic [ZW-1:0] cur_z_ff, cur_z_in;
   logic [MW-1:0] cur_c_ff, cur_c_in;
   logic [SW-1:0] an_ff [NB];
   logic [SW-1:0] ai_ff, ai_in;
   logic [NB-1:0] ok_ff, ok_in;
   logic [IW-1:0] acc_ff, acc_in;
   logic [IW-1:0] plane_ff, plane_in;
   logic [IW-1:0] row_ff, row_in;
   logic [IW-1:0] col_ff, col_in;
   logic          last_ff, last_in;
   logic [KW-1:0] kidx_ff, kidx_in;

   // handshake and control
   logic          req_take;
   logic          rsp_take;
   logic          kidx_end;
   logic          pick_ok;
   logic          arith_start;
   logic          arith_done;
   logic [sem_pkg::VAL_W-1:0] arith_value;
   sem_pkg::sem_arith_req_type arith_req;

   // normalized counters and neighbour flags
   logic [XW-1:0] x_norm;
   logic [YW-1:0] y_norm;
   logic [ZW-1:0] z_norm;
   logic [MW-1:0] c_norm;
   logic          x_inc_ok, y_inc_ok, z_inc_ok;
   logic [NB-1:0] ok_vec;
   logic [SW-1:0] ai_sel;
   logic [IW-1:0] col_sel;
   logic [CW-1:0] coef_sel;
   logic          last_sel;

   assign req_take = req_valid && req_ready;
   assign rsp_take = rsp_valid && rsp_ready;
   assign kidx_end = (kidx_ff == KW'(NB));
   assign pick_ok  = !kidx_end && ok_ff[kidx_ff];

   always_comb begin
      x_norm   = (cell_x_ff >= nx) ? '0 : cell_x_ff;
      y_norm   = (cell_y_ff >= ny) ? '0 : cell_y_ff;
      z_norm   = (cell_z_ff >= nz) ? '0 : cell_z_ff;
      c_norm   = (comp_ff >= MW'(sem_pkg::COMPONENTS)) ? '0 : comp_ff;
      x_inc_ok = ((XW+1)'(x_norm) + (XW+1)'(1)) < (XW+1)'(nx);
      y_inc_ok = ((YW+1)'(y_norm) + (YW+1)'(1)) < (YW+1)'(ny);
      z_inc_ok = ((ZW+1)'(z_norm) + (ZW+1)'(1)) < (ZW+1)'(nz);
      ok_vec   = {z_norm != '0, z_inc_ok, y_norm != '0, y_inc_ok,
                  x_norm != '0, x_inc_ok};
      ai_sel   = uniform_ff ? ustiff_ff : req_a_self;
   end

   // neighbour column, coefficient and last flag for the current slot
   always_comb begin
      case (kidx_ff)
         sem_pkg::NBR_XP: begin
            col_sel  = row_ff + IW'(1);
            coef_sel = coef_x_ff;
         end
         sem_pkg::NBR_XM: begin
            col_sel  = row_ff - IW'(1);
            coef_sel = coef_x_ff;
         end
         sem_pkg::NBR_YP: begin
            col_sel  = row_ff + IW'(nx);
            coef_sel = coef_y_ff;
         end
         sem_pkg::NBR_YM: begin
            col_sel  = row_ff - IW'(nx);
            coef_sel = coef_y_ff;
         end
         sem_pkg::NBR_ZP: begin
            col_sel  = row_ff + plane_ff;
            coef_sel = coef_z_ff;
         end
         sem_pkg::NBR_ZM: begin
            col_sel  = row_ff - plane_ff;
            coef_sel = coef_z_ff;
         end
         default: begin
            col_sel  = row_ff;
            coef_sel = coef_z_ff;
         end
      endcase
      last_sel = ((ok_ff >> (kidx_ff + KW'(1))) == '0);
   end

   always_comb begin
      arith_req.coef    = coef_sel;
      arith_req.ai      = ai_ff;
      arith_req.an      = an_ff[kidx_ff];
      arith_req.uniform = uniform_ff;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         sem_pkg::ST_IDLE: begin
            if (req_take) state_in = sem_pkg::ST_ROW_Z;
         end
         sem_pkg::ST_ROW_Z: state_in = sem_pkg::ST_ROW_Y;
         sem_pkg::ST_ROW_Y: state_in = sem_pkg::ST_ROW_X;
         sem_pkg::ST_ROW_X: state_in = sem_pkg::ST_SCAN;
         sem_pkg::ST_SCAN: begin
            if (kidx_end) state_in = sem_pkg::ST_IDLE;
            else if (pick_ok) state_in = sem_pkg::ST_CALC;
         end
         sem_pkg::ST_CALC: begin
            if (arith_done) state_in = sem_pkg::ST_EMIT;
         end
         sem_pkg::ST_EMIT: begin
            if (rsp_ready) state_in = sem_pkg::ST_SCAN;
         end
         default: state_in = sem_pkg::ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      req_ready       = (state_ff == sem_pkg::ST_IDLE);
      rsp_valid       = (state_ff == sem_pkg::ST_EMIT);
      arith_start     = (state_ff == sem_pkg::ST_SCAN) && pick_ok;
      rsp_row_index   = row_ff;
      rsp_col_index   = col_ff;
      rsp_entry_value = arith_value;
      rsp_row_last    = last_ff;
   end

   // datapath next values
   always_comb begin
      cell_x_in = cell_x_ff;
      cell_y_in = cell_y_ff;
      cell_z_in = cell_z_ff;
      comp_in   = comp_ff;
      cur_x_in  = cur_x_ff;
      cur_y_in  = cur_y_ff;
      cur_z_in  = cur_z_ff;
      cur_c_in  = cur_c_ff;
      ai_in     = ai_ff;
      ok_in     = ok_ff;
      acc_in    = acc_ff;
      plane_in  = plane_ff;
      row_in    = row_ff;
      col_in    = col_ff;
      last_in   = last_ff;
      kidx_in   = kidx_ff;
      case (state_ff)
         sem_pkg::ST_IDLE: begin
            if (req_take) begin
               cur_x_in = x_norm;
               cur_y_in = y_norm;
               cur_z_in = z_norm;
               cur_c_in = c_norm;
               ai_in    = ai_sel;
               ok_in    = (uniform_ff || ai_sel != '0) ? ok_vec : '0;
               cell_x_in = x_inc_ok ? (x_norm + XW'(1)) : '0;
               cell_y_in = y_norm;
               cell_z_in = z_norm;
               comp_in   = c_norm;
               if (!x_inc_ok) begin
                  cell_y_in = y_inc_ok ? (y_norm + YW'(1)) : '0;
                  if (!y_inc_ok) begin
                     cell_z_in = z_inc_ok ? (z_norm + ZW'(1)) : '0;
                     if (!z_inc_ok) begin
                        comp_in = (c_norm == MW'(sem_pkg::COMPONENTS - 1)) ? '0 :
                                  (c_norm + MW'(1));
                     end
                  end
               end
            end
         end
         sem_pkg::ST_ROW_Z: begin
            acc_in   = IW'(cur_z_ff) + IW'(IW'(nz) * IW'(cur_c_ff));
            plane_in = IW'(IW'(nx) * IW'(ny));
         end
         sem_pkg::ST_ROW_Y: begin
            acc_in = IW'(cur_y_ff) + IW'(IW'(ny) * acc_ff);
         end
         sem_pkg::ST_ROW_X: begin
            row_in  = IW'(cur_x_ff) + IW'(IW'(nx) * acc_ff);
            kidx_in = '0;
         end
         sem_pkg::ST_SCAN: begin
            if (pick_ok) begin
               col_in  = col_sel;
               last_in = last_sel;
            end else if (!kidx_end) begin
               kidx_in = kidx_ff + KW'(1);
            end
         end
         sem_pkg::ST_CALC: ;
         sem_pkg::ST_EMIT: begin
            if (rsp_take) kidx_in = kidx_ff + KW'(1);
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= sem_pkg::ST_IDLE;
         cell_x_ff <= '0;
         cell_y_ff <= '0;
         cell_z_ff <= '0;
         comp_ff   <= '0;
         kidx_ff   <= '0;
      end else begin
         state_ff  <= state_in;
         cell_x_ff <= cell_x_in;
         cell_y_ff <= cell_y_in;
         cell_z_ff <= cell_z_in;
         comp_ff   <= comp_in;
         kidx_ff   <= kidx_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_x_ff <= cur_x_in;
      cur_y_ff <= cur_y_in;
      cur_z_ff <= cur_z_in;
      cur_c_ff <= cur_c_in;
      ai_ff    <= ai_in;
      ok_ff    <= ok_in;
      acc_ff   <= acc_in;
      plane_ff <= plane_in;
      row_ff   <= row_in;
      col_ff   <= col_in;
      last_ff  <= last_in;
      if (req_take) begin
         an_ff[0] <= req_a_xp;
         an_ff[1] <= req_a_xm;
         an_ff[2] <= req_a_yp;
         an_ff[3] <= req_a_ym;
         an_ff[4] <= req_a_zp;
         an_ff[5] <= req_a_zm;
      end
   end

   sem_arith u_arith (
      .clock (clock),
      .reset (reset),
      .start (arith_start),
      .req   (arith_req),
      .done  (arith_done),
      .value (arith_value)
   );

endmodule
